### rtl/tpcr_pkg.sv
// Shared types, sizes and tables for the trail point Catmull-Rom smoother.
// Depends on nothing; the step unit, top level, checker and testbench import it.
`default_nettype none

package tpcr_pkg;

  localparam int TRAIL_POINTS = 32;
  localparam int STORE_DEPTH  = TRAIL_POINTS - 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int VTX_W        = $clog2(TRAIL_POINTS);
  localparam int ECNT_W       = $clog2(TRAIL_POINTS + 1);
  localparam int AXES         = 3;

  localparam int COORD_W = 32;
  localparam int INDEX_W = 6;
  localparam int TEXV_W  = 17;

  localparam int IN_W      = 6 * COORD_W;
  localparam int OUT_U_LSB = INDEX_W + 3 * COORD_W;
  localparam int OUT_V_LSB = OUT_U_LSB + 1;
  localparam int OUT_W     = OUT_V_LSB + TEXV_W;

  localparam int FIRST_STEP = 2;
  localparam int LAST_STEP  = TRAIL_POINTS - 3;
  localparam int FLUSH_BASE = TRAIL_POINTS - 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SWEEP,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TEXV_W-1:0]  tex_v_t;
  typedef tex_v_t             tex_v_table_t [TRAIL_POINTS];

  typedef struct packed {
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
  } window_t;

  typedef struct packed {
    logic              valid;
    axis_t             axis;
    logic [ADDR_W-1:0] addr;
  } fetch_t;

  typedef struct packed {
    logic   valid;
    axis_t  axis;
    coord_t p0;
    coord_t p1;
    coord_t p2;
  } result_t;

  function automatic tex_v_table_t build_tex_v();
    tex_v_table_t t;
    for (int k = 0; k < TRAIL_POINTS; k++) begin
      if (k == 0) begin
        t[k] = '0;
      end else begin
        t[k] = TEXV_W'(((k - 1) << 16) / (TRAIL_POINTS - 2));
      end
    end
    return t;
  endfunction

  localparam tex_v_table_t TEX_V = build_tex_v();

endpackage

`default_nettype wire

### rtl/tpcr_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`default_nettype none

module tpcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/tpcr_step_unit.sv
// Pipelined smoothing step unit shared by the three axes in turn.
// Depends on tpcr_pkg.
`default_nettype none

module tpcr_step_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue_valid,
  input  tpcr_pkg::axis_t               issue_axis,
  input  logic [tpcr_pkg::ADDR_W-1:0]   issue_step,
  input  tpcr_pkg::window_t             issue_win,
  output tpcr_pkg::fetch_t              fetch,
  output tpcr_pkg::result_t             result
);

  import tpcr_pkg::*;

  localparam int SUM_W = COORD_W + 1;
  localparam int ACC_W = COORD_W + 6;
  localparam int MID_W = COORD_W + 2;
  localparam int HLF_W = MID_W + 1;

  function automatic coord_t sat(input logic [MID_W-1:0] v);
    logic [MID_W-COORD_W:0] top;
    top = v[MID_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end else if (v[MID_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic [SUM_W-1:0]  sum_e, sum_f, sum_d;
  logic [SUM_W-1:0]  a_e, a_f;
  coord_t            a_d, a_p1, a_p2;
  axis_t             a_axis;
  logic              a_valid;
  logic [ADDR_W-1:0] a_addr;
  logic [ACC_W-1:0]  acc;
  logic [MID_W-1:0]  b_m;
  coord_t            b_d, b_p1, b_p2;
  axis_t             b_axis;
  logic              b_valid;
  logic [HLF_W-1:0]  half_b, half_c;

  assign sum_e = {issue_win.p1[COORD_W-1], issue_win.p1}
               + {issue_win.p2[COORD_W-1], issue_win.p2};
  assign sum_f = {issue_win.p0[COORD_W-1], issue_win.p0}
               + {issue_win.p3[COORD_W-1], issue_win.p3};
  assign sum_d = {issue_win.p2[COORD_W-1], issue_win.p2}
               + {issue_win.p3[COORD_W-1], issue_win.p3};

  // Nine times the inner sum less the outer sum; the midpoint is its top bits.
  assign acc = {{5{a_e[SUM_W-1]}}, a_e}
             + {{2{a_e[SUM_W-1]}}, a_e, 3'b000}
             - {{5{a_f[SUM_W-1]}}, a_f};

  assign half_b = {b_m[MID_W-1], b_m} + {{3{b_p1[COORD_W-1]}}, b_p1};
  assign half_c = {b_m[MID_W-1], b_m} + {{3{b_p2[COORD_W-1]}}, b_p2};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= issue_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_e    <= sum_e;
    a_f    <= sum_f;
    a_d    <= sum_d[SUM_W-1:1];
    a_p1   <= issue_win.p1;
    a_p2   <= issue_win.p2;
    a_axis <= issue_axis;
    a_addr <= issue_step + ADDR_W'(1);
    b_m    <= acc[ACC_W-1:4];
    b_d    <= a_d;
    b_p1   <= a_p1;
    b_p2   <= a_p2;
    b_axis <= a_axis;
  end

  assign fetch.valid = a_valid;
  assign fetch.axis  = a_axis;
  assign fetch.addr  = a_addr;

  assign result.valid = b_valid;
  assign result.axis  = b_axis;
  assign result.p0    = sat(half_b[HLF_W-1:1]);
  assign result.p1    = sat(half_c[HLF_W-1:1]);
  assign result.p2    = b_d;

endmodule

`default_nettype wire

### rtl/trail_point_catmull_rom_smoother_core.sv
// Top level of the trail point Catmull-Rom smoother: sequencer, point stores and output stage.
// Depends on tpcr_pkg, tpcr_ram and tpcr_step_unit.
`default_nettype none

// Each request carries a new trail head and a base point. The head is pushed into a store of
// TRAIL_POINTS-1 past points, the store is smoothed in place, and TRAIL_POINTS vertices come
// out: the base point first, then the stored points, the final one with tlast set. A request
// passes through these steps: it is taken, the window is primed, TRAIL_POINTS-4 smoothing
// steps run with the x, y and z axes in turn, because one shared step unit serves them all and
// each axis waits for its own result, the step unit drains, the window tail is written back,
// then one vertex a cycle comes from the point memories while the output is not stalled, and
// the last vertex passes into the output register. s_tready is high only while the block is
// idle; the last vertex may still be waiting on the output when the next request is taken.
module trail_point_catmull_rom_smoother_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // head_x, head_y, head_z, base_x, base_y, base_z
  input  logic [tpcr_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // vertex_index, pos_x, pos_y, pos_z, tex_u_one, tex_v
  output logic [tpcr_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tlast
);

  import tpcr_pkg::*;

  state_t            state, state_next;
  logic [1:0]        cnt;
  axis_t             iss_ax;
  logic [ADDR_W-1:0] iss_step;
  logic              iss_done;
  logic              issue_valid;
  logic              primed;
  window_t           win [AXES];
  coord_t            base_x, base_y, base_z;
  logic [ECNT_W-1:0] ek;
  logic              rv;
  logic [VTX_W-1:0]  rk;
  logic              out_load;
  logic              emit_issue;
  logic [AXES-1:0]   ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  coord_t            ram_rdata [AXES];
  coord_t            rd_val [AXES];
  fetch_t            fetch;
  result_t           result;
  logic [ECNT_W-1:0] ek_prev;
  coord_t            vx, vy, vz;

  function automatic axis_t next_axis(input axis_t a);
    case (a)
      AX_X:    return AX_Y;
      AX_Y:    return AX_Z;
      default: return AX_X;
    endcase
  endfunction

  for (genvar k = 0; k < AXES; k++) begin : g_store
    tpcr_ram #(
      .WIDTH(COORD_W),
      .DEPTH(STORE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[k]),
      .waddr (ram_waddr),
      .wdata (win[k].p0),
      .re    (ram_re[k]),
      .raddr (ram_raddr),
      .rdata (ram_rdata[k])
    );
    assign rd_val[k] = primed ? ram_rdata[k] : '0;
  end

  tpcr_step_unit u_step (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue_axis  (iss_ax),
    .issue_step  (iss_step),
    .issue_win   (win[iss_ax]),
    .fetch       (fetch),
    .result      (result)
  );

  assign out_load = rv && (!m_tvalid || m_tready);
  assign ek_prev  = ek - ECNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt == 2'd3) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (iss_done && !fetch.valid && !result.valid) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (cnt == 2'd2) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ek == ECNT_W'(TRAIL_POINTS) && !rv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    issue_valid = 1'b0;
    emit_issue  = 1'b0;
    ram_we      = '0;
    ram_re      = '0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_FILL: begin
        ram_re    = (cnt != 2'd3) ? '1 : '0;
        ram_raddr = ADDR_W'(cnt);
      end
      ST_SWEEP: begin
        issue_valid = !iss_done;
        if (issue_valid) begin
          ram_we[iss_ax] = 1'b1;
          ram_waddr      = iss_step - ADDR_W'(FIRST_STEP);
        end
        if (fetch.valid) begin
          ram_re[fetch.axis] = 1'b1;
          ram_raddr          = fetch.addr;
        end
      end
      ST_FLUSH: begin
        ram_we    = '1;
        ram_waddr = ADDR_W'(FLUSH_BASE) + ADDR_W'(cnt);
      end
      ST_EMIT: begin
        emit_issue = (ek != ECNT_W'(TRAIL_POINTS)) && (!rv || out_load);
        if (emit_issue && ek != '0) begin
          ram_re    = '1;
          ram_raddr = ek_prev[ADDR_W-1:0];
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      iss_ax   <= AX_X;
      iss_step <= ADDR_W'(FIRST_STEP);
      iss_done <= 1'b0;
      primed   <= 1'b0;
      ek       <= '0;
      rv       <= 1'b0;
      rk       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else if (state == ST_FILL || state == ST_FLUSH) begin
        cnt <= cnt + 2'd1;
      end
      if (state == ST_FILL) begin
        iss_ax   <= AX_X;
        iss_step <= ADDR_W'(FIRST_STEP);
        iss_done <= 1'b0;
      end else if (issue_valid) begin
        iss_ax <= next_axis(iss_ax);
        if (iss_ax == AX_Z) begin
          if (iss_step == ADDR_W'(LAST_STEP)) begin
            iss_done <= 1'b1;
          end else begin
            iss_step <= iss_step + ADDR_W'(1);
          end
        end
      end
      if (state == ST_FLUSH && state_next == ST_EMIT) begin
        primed <= 1'b1;
      end
      if (state != ST_EMIT) begin
        ek <= '0;
      end else if (emit_issue) begin
        ek <= ek + ECNT_W'(1);
      end
      if (emit_issue) begin
        rv <= 1'b1;
        rk <= ek[VTX_W-1:0];
      end else if (out_load) begin
        rv <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Vertex zero is the base point; every later vertex comes from the point memories.
  assign vx = (rk == '0) ? base_x : ram_rdata[AX_X];
  assign vy = (rk == '0) ? base_y : ram_rdata[AX_Y];
  assign vz = (rk == '0) ? base_z : ram_rdata[AX_Z];

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      win[AX_X].p0 <= s_tdata[COORD_W-1:0];
      win[AX_Y].p0 <= s_tdata[2*COORD_W-1:COORD_W];
      win[AX_Z].p0 <= s_tdata[3*COORD_W-1:2*COORD_W];
      base_x       <= s_tdata[4*COORD_W-1:3*COORD_W];
      base_y       <= s_tdata[5*COORD_W-1:4*COORD_W];
      base_z       <= s_tdata[6*COORD_W-1:5*COORD_W];
    end else if (state == ST_FILL && cnt != '0) begin
      for (int k = 0; k < AXES; k++) begin
        win[k].p1 <= win[k].p2;
        win[k].p2 <= win[k].p3;
        win[k].p3 <= rd_val[k];
      end
    end else if (state == ST_SWEEP && result.valid) begin
      win[result.axis].p0 <= result.p0;
      win[result.axis].p1 <= result.p1;
      win[result.axis].p2 <= result.p2;
      win[result.axis].p3 <= rd_val[result.axis];
    end else if (state == ST_FLUSH) begin
      for (int k = 0; k < AXES; k++) begin
        win[k].p0 <= win[k].p1;
        win[k].p1 <= win[k].p2;
      end
    end
    if (out_load) begin
      m_tdata <= {TEX_V[rk], rk == '0, vz, vy, vx, INDEX_W'(rk)};
      m_tlast <= (rk == VTX_W'(TRAIL_POINTS - 1));
    end
  end

endmodule

`default_nettype wire

### rtl/tpcr_checker.sv
// Port-level checks for the trail point smoother, bound to the top level.
// Depends on tpcr_pkg and trail_point_catmull_rom_smoother_core.
`default_nettype none

module tpcr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [tpcr_pkg::OUT_W-1:0]   m_tdata,
  input logic                         m_tlast
);

  import tpcr_pkg::*;

  logic [INDEX_W-1:0] idx;

  assign idx = m_tdata[INDEX_W-1:0];

  // A stalled vertex keeps its contents until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled vertex changed");

  // The block works on one request at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> idx == INDEX_W'(TRAIL_POINTS - 1))
    else $error("tlast on a vertex other than the final one");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && idx == '0 |-> m_tdata[OUT_U_LSB] && m_tdata[OUT_W-1:OUT_V_LSB] == '0
                              && !s_tready && !m_tlast)
    else $error("base vertex malformed or shown while idle");

endmodule

bind trail_point_catmull_rom_smoother_core tpcr_checker u_checker (.*);

`default_nettype wire

### dv/trail_point_catmull_rom_smoother_core_tb.sv
// Self-checking testbench for trail_point_catmull_rom_smoother_core: directed table, then
// random requests, every vertex checked against an in-bench trail smoothing predictor.
// Depends on tpcr_pkg and the smoother core RTL.
module trail_point_catmull_rom_smoother_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpcr_pkg::*;

  localparam coord_t MAXC = 32'h7FFF_FFFF;
  localparam coord_t MINC = 32'h8000_0000;
  localparam int RANDOM_REQUESTS = 460;
  localparam int PAUSE_AT        = 100;
  localparam int STEADY_FROM     = 200;
  localparam int STEADY_TO       = 260;
  localparam int HOLD_AT         = 320 * TRAIL_POINTS;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 200;
  localparam int STALL_LIMIT     = 4000;

  typedef struct packed {
    coord_t hx, hy, hz;
    coord_t bx, by, bz;
  } request_t;

  typedef struct packed {
    coord_t hx, hy, hz;
    coord_t bx, by, bz;
    logic   typed;
    coord_t typed_pos;
  } dir_row_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    coord_t             x, y, z;
    logic               u;
    logic [TEXV_W-1:0]  v;
    logic               last;
  } vertex_t;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;

  int      trail [AXES][STORE_DEPTH];
  vertex_t pending_vertices [$];
  int      mismatches;
  int      vertices_seen;
  bit      steady;
  coord_t  walk [AXES];

  // Rows marked typed are the first requests after reset with a zero head, so the whole
  // trail must still be zero.
  dir_row_t directed [18] = '{
    '{32'h0, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 1'b1, 32'h0},
    '{32'h0, 32'h0, 32'h0, MAXC, MINC, 32'h0, 1'b1, 32'h0},
    '{32'h0, 32'h0, 32'h0, MINC, MAXC, 32'hFFFF_FFFF, 1'b1, 32'h0},
    '{MAXC, MINC, MAXC, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{MINC, MAXC, MAXC, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{MINC, MAXC, MINC, MAXC, MAXC, MAXC, 1'b0, 32'h0},
    '{MAXC, MINC, MINC, MINC, MINC, MINC, 1'b0, 32'h0},
    '{MAXC, MINC, MAXC, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{MINC, MAXC, MAXC, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{MAXC, MAXC, MINC, 32'h1, 32'h1, 32'h1, 1'b0, 32'h0},
    '{MINC, MINC, MINC, MAXC, MAXC, MAXC, 1'b0, 32'h0},
    '{MAXC, MAXC, MAXC, MINC, MINC, MINC, 1'b0, 32'h0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h8000_0001, 1'b0, 32'h0},
    '{32'h7FFF_0000, 32'h8001_0000, 32'h0, 32'h0000_FFFF, 32'h1, 32'h7FFF_FFFE, 1'b0, 32'h0},
    '{32'h1, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0}
  };

  trail_point_catmull_rom_smoother_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic void advance_axis(int a, coord_t head);
    longint p0, p1, p2, p3, mid;
    for (int i = STORE_DEPTH - 1; i > 0; i--) trail[a][i] = trail[a][i-1];
    trail[a][0] = int'(head);
    for (int i = 2; i <= TRAIL_POINTS - 3; i++) begin
      p0  = trail[a][i-2];
      p1  = trail[a][i-1];
      p2  = trail[a][i];
      p3  = trail[a][i+1];
      mid = (-p0 + 9 * p1 + 9 * p2 - p3) >>> 4;
      trail[a][i+1] = clamp32((p2 + p3) >>> 1);
      trail[a][i]   = clamp32((mid + p2) >>> 1);
      trail[a][i-1] = clamp32((mid + p1) >>> 1);
    end
  endfunction

  function automatic void smooth_trail(request_t r, bit typed, coord_t typed_pos);
    vertex_t vx;
    advance_axis(AX_X, r.hx);
    advance_axis(AX_Y, r.hy);
    advance_axis(AX_Z, r.hz);
    vx = '{idx: '0, x: r.bx, y: r.by, z: r.bz, u: 1'b1, v: '0, last: 1'b0};
    pending_vertices.push_back(vx);
    for (int k = 1; k < TRAIL_POINTS; k++) begin
      vx.idx  = INDEX_W'(k);
      vx.x    = typed ? typed_pos : coord_t'(trail[AX_X][k-1]);
      vx.y    = typed ? typed_pos : coord_t'(trail[AX_Y][k-1]);
      vx.z    = typed ? typed_pos : coord_t'(trail[AX_Z][k-1]);
      vx.u    = 1'b0;
      vx.v    = TEXV_W'(((k - 1) << 16) / (TRAIL_POINTS - 2));
      vx.last = (k == TRAIL_POINTS - 1);
      pending_vertices.push_back(vx);
    end
  endfunction

  function automatic bit take_gap();
    return !steady && $urandom_range(99) < 35;
  endfunction

  function automatic coord_t pick_coord(coord_t prev);
    int unsigned mode;
    int          step;
    coord_t      corner [5];
    mode   = $urandom_range(99);
    step   = int'($urandom_range(2097152)) - 1048576;
    corner = '{MAXC, MINC, 32'h0, 32'hFFFF_FFFF, 32'h1};
    if (mode < 50) return prev + coord_t'(step);
    if (mode < 70) return $urandom();
    if (mode < 85) return corner[$urandom_range(4)];
    return $urandom_range(1) ? MAXC - $urandom_range(4095) : MINC + $urandom_range(4095);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at vertex %0d, %s: got %0h, expected %0h",
             vertices_seen, field, got, want);
    mismatches++;
  endtask

  task automatic offer(request_t r, bit typed, coord_t typed_pos);
    s_tvalid <= 1'b1;
    s_tdata  <= {r.bz, r.by, r.bx, r.hz, r.hy, r.hx};
    do @(posedge clk); while (!s_tready);
    smooth_trail(r, typed, typed_pos);
  endtask

  task automatic sender_gap();
    while (take_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    request_t req;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[n]) begin
      sender_gap();
      req = '{directed[n].hx, directed[n].hy, directed[n].hz,
              directed[n].bx, directed[n].by, directed[n].bz};
      offer(req, directed[n].typed, directed[n].typed_pos);
    end
    walk = '{32'h0, 32'h0, 32'h0};
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      if (n == PAUSE_AT) begin
        s_tvalid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
      foreach (walk[a]) walk[a] = pick_coord(walk[a]);
      req.hx = walk[AX_X];
      req.hy = walk[AX_Y];
      req.hz = walk[AX_Z];
      req.bx = ($urandom_range(99) < 80) ? $urandom() : pick_coord(32'h0);
      req.by = ($urandom_range(99) < 80) ? $urandom() : pick_coord(32'h0);
      req.bz = ($urandom_range(99) < 80) ? $urandom() : pick_coord(32'h0);
      offer(req, 1'b0, '0);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : receiver
    vertex_t got, want;
    int      holdoff_left;
    bit      held;
    holdoff_left = 0;
    held         = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.idx  = m_tdata[INDEX_W-1:0];
        got.x    = m_tdata[INDEX_W +: COORD_W];
        got.y    = m_tdata[INDEX_W + COORD_W +: COORD_W];
        got.z    = m_tdata[INDEX_W + 2 * COORD_W +: COORD_W];
        got.u    = m_tdata[OUT_U_LSB];
        got.v    = m_tdata[OUT_V_LSB +: TEXV_W];
        got.last = m_tlast;
        if (pending_vertices.size() == 0) begin
          report_mismatch("vertex with no request outstanding", got.idx, '0);
        end else begin
          want = pending_vertices.pop_front();
          if (got.idx != want.idx) report_mismatch("vertex_index", got.idx, want.idx);
          if (got.x != want.x) report_mismatch("pos_x", got.x, want.x);
          if (got.y != want.y) report_mismatch("pos_y", got.y, want.y);
          if (got.z != want.z) report_mismatch("pos_z", got.z, want.z);
          if (got.u != want.u) report_mismatch("tex_u_one", got.u, want.u);
          if (got.v != want.v) report_mismatch("tex_v", got.v, want.v);
          if (got.last != want.last) report_mismatch("last_vertex", got.last, want.last);
        end
        vertices_seen++;
        if (vertices_seen == HOLD_AT && !held) begin
          held         = 1'b1;
          holdoff_left = HOLD_CYCLES;
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || $urandom_range(99) >= 35;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
